### hw/rtl/bad_pkg.sv
// Shared types and constants for the RGB block average downsampler.
package bad_pkg;

    localparam int CH_W   = 8;
    localparam int SUM_W  = 29;
    localparam int NUM_CH = 3;

    // Configuration register indexes.
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BLOCK_WIDTH  = 2'd2;
    localparam logic [1:0] REG_BLOCK_HEIGHT = 2'd3;

    typedef logic [CH_W-1:0]  chan_t;
    typedef logic [SUM_W-1:0] sum_t;

    // Handshake between the control logic and the divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### hw/rtl/rgb_block_average_downsampler.sv
// Top level of the RGB block average downsampler.
//
//  Channel   Direction  Signals                          Contents
//  s_*       in         s_tvalid s_tready s_tdata[23:0]  one pixel
//  m_*       out        m_tvalid m_tready m_tdata[23:0]  one tile average
//                       m_tlast m_tuser[0:0]             row end, frame end
//  cfg_*     in         cfg_we cfg_addr cfg_data         register writes
//
// A pixel outside any full tile leaves the sequencer idle; one inside a full tile also
// passes the read-modify-write state (memory read, then add and write back). The last
// pixel of a tile then passes the divider (eight quotient steps and a done flag) and
// the load of the output register, which waits while that register holds an unsent result.
// No clearing pass runs after reset: the first pixel of a tile overwrites its entry.
module rgb_block_average_downsampler #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pix_red, pix_green, pix_blue
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // avg_red, avg_green, avg_blue
    output logic        m_tlast,   // row_end
    output logic [0:0]  m_tuser,   // frame_end
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [11:0] cfg_data
);
    import bad_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int AREA_W = WW + HW;
    localparam int XW     = WW + 2;
    localparam int YW     = HW + 2;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RMW  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [WW-1:0]     iw_reg, bw_reg;
    logic [HW-1:0]     ih_reg, bh_reg;
    logic [AREA_W-1:0] area_reg;
    logic [CW-1:0]     col_reg, cit_reg, tc_reg;
    logic [RW-1:0]     row_reg, rit_reg;
    logic [CW-1:0]     addr_reg;
    chan_t             pix_reg [NUM_CH];
    logic              first_reg, done_reg, lastc_reg, lastr_reg;
    logic              out_valid_reg;
    chan_t             out_pix_reg [NUM_CH];
    logic              out_row_reg, out_frame_reg;

    logic              accept;
    logic [XW-1:0]     tile_x0, x_end;
    logic [YW-1:0]     tile_y0, y_end;
    logic              full;
    logic [WW-1:0]     col1, cit1;
    logic [HW-1:0]     row1, rit1;
    logic [WW-1:0]     cfg_w;
    logic [HW-1:0]     cfg_h;
    sum_t [NUM_CH-1:0] rd_data, sum_new;
    chan_t [NUM_CH-1:0] quot;
    div_stat_t         div_stat;
    logic              div_start, mem_we, out_load;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    // Clamp: zero acts as one, oversize as maximum; height reads only cfg_data[10:0].
    always_comb
    begin
        if (cfg_data == '0)
            cfg_w = WW'(1);
        else if (32'(cfg_data) > MAX_WIDTH)
            cfg_w = WW'(MAX_WIDTH);
        else
            cfg_w = WW'(cfg_data);
        if (cfg_data[10:0] == '0)
            cfg_h = HW'(1);
        else if (32'(cfg_data[10:0]) > MAX_HEIGHT)
            cfg_h = HW'(MAX_HEIGHT);
        else
            cfg_h = HW'(cfg_data[10:0]);
    end

    // Configuration registers and the registered tile area.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iw_reg   <= WW'(1);
            ih_reg   <= HW'(1);
            bw_reg   <= WW'(1);
            bh_reg   <= HW'(1);
            area_reg <= AREA_W'(1);
        end
        else
        begin
            area_reg <= AREA_W'(bw_reg) * AREA_W'(bh_reg);
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_IMAGE_WIDTH:  iw_reg <= cfg_w;
                    REG_IMAGE_HEIGHT: ih_reg <= cfg_h;
                    REG_BLOCK_WIDTH:  bw_reg <= cfg_w;
                    REG_BLOCK_HEIGHT: bh_reg <= cfg_h;
                    default:          iw_reg <= iw_reg;
                endcase
            end
        end
    end

    // Tile position of the current pixel and whether its tile fits.
    always_comb
    begin
        tile_x0 = XW'(col_reg) - XW'(cit_reg);
        tile_y0 = YW'(row_reg) - YW'(rit_reg);
        x_end   = tile_x0 + XW'(bw_reg);
        y_end   = tile_y0 + YW'(bh_reg);
        full    = (x_end <= XW'(iw_reg)) && (y_end <= YW'(ih_reg));
        col1    = WW'(col_reg) + WW'(1);
        cit1    = WW'(cit_reg) + WW'(1);
        row1    = HW'(row_reg) + HW'(1);
        rit1    = HW'(rit_reg) + HW'(1);
    end

    // Position counters; any configuration write restarts the frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            cit_reg <= '0;
            tc_reg  <= '0;
            row_reg <= '0;
            rit_reg <= '0;
        end
        else if (cfg_we)
        begin
            col_reg <= '0;
            cit_reg <= '0;
            tc_reg  <= '0;
            row_reg <= '0;
            rit_reg <= '0;
        end
        else if (accept)
        begin
            if (col1 >= iw_reg)
            begin
                col_reg <= '0;
                cit_reg <= '0;
                tc_reg  <= '0;
                if (row1 >= ih_reg)
                begin
                    row_reg <= '0;
                    rit_reg <= '0;
                end
                else
                begin
                    row_reg <= row1[RW-1:0];
                    rit_reg <= (rit1 >= bh_reg) ? '0 : rit1[RW-1:0];
                end
            end
            else
            begin
                col_reg <= col1[CW-1:0];
                if (cit1 >= bw_reg)
                begin
                    cit_reg <= '0;
                    tc_reg  <= tc_reg + CW'(1);
                end
                else
                begin
                    cit_reg <= cit1[CW-1:0];
                end
            end
        end
    end

    // Pixel and tile flags held for the read-modify-write cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg   <= tc_reg;
            pix_reg[0] <= s_tdata[7:0];
            pix_reg[1] <= s_tdata[15:8];
            pix_reg[2] <= s_tdata[23:16];
            first_reg  <= (cit_reg == '0) && (rit_reg == '0);
            done_reg   <= (WW'(cit_reg) == bw_reg - WW'(1))
                       && (HW'(rit_reg) == bh_reg - HW'(1));
            lastc_reg  <= (x_end + XW'(bw_reg)) > XW'(iw_reg);
            lastr_reg  <= (y_end + YW'(bh_reg)) > YW'(ih_reg);
        end
    end

    // New sums: the first pixel of a tile overwrites the entry.
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            sum_new[c] = first_reg ? SUM_W'(pix_reg[c]) : rd_data[c] + SUM_W'(pix_reg[c]);
        end
    end

    assign mem_we    = (state_reg == S_RMW);
    assign div_start = mem_we && done_reg;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || m_tready);

    bad_acc_mem #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (CW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (tc_reg),
        .rd_data (rd_data),
        .wr_en   (mem_we),
        .wr_addr (addr_reg),
        .wr_data (sum_new)
    );

    bad_div #(
        .AREA_W (AREA_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sums  (sum_new),
        .area  (area_reg),
        .quot  (quot),
        .stat  (div_stat)
    );

    // Sequencer for one pixel at a time.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && full)
                    state_next = S_RMW;
            end
            S_RMW:
            begin
                state_next = done_reg ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                if (div_stat.done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Output register; it holds a result until its transfer.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                out_pix_reg[c] <= quot[c];
            end
            out_row_reg   <= lastc_reg;
            out_frame_reg <= lastc_reg && lastr_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pix_reg[2], out_pix_reg[1], out_pix_reg[0]};
    assign m_tlast  = out_row_reg;
    assign m_tuser  = out_frame_reg;

    // The divider is started only when it is free.
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // A divider result arrives only while the sequencer waits for it.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider result outside the divide state");

    // No memory read is issued in the same cycle as a write back.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !accept)
        else $error("memory read overlaps write back");

endmodule

### hw/rtl/bad_acc_mem.sv
// Per tile column accumulator memory holding the three channel sums.
module bad_acc_mem #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic                                  clk,
    input  logic                                  rd_en,
    input  logic [ADDR_W-1:0]                     rd_addr,
    output bad_pkg::sum_t [bad_pkg::NUM_CH-1:0]   rd_data,
    input  logic                                  wr_en,
    input  logic [ADDR_W-1:0]                     wr_addr,
    input  bad_pkg::sum_t [bad_pkg::NUM_CH-1:0]   wr_data
);
    import bad_pkg::*;

    logic [NUM_CH*SUM_W-1:0] mem [DEPTH];

    // Synchronous write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Synchronous read port; the read data is registered.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/bad_div.sv
// Restoring divider that turns three channel sums into 8-bit averages.
module bad_div #(
    parameter int AREA_W = 23
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  bad_pkg::sum_t [bad_pkg::NUM_CH-1:0]   sums,
    input  logic [AREA_W-1:0]                     area,
    output bad_pkg::chan_t [bad_pkg::NUM_CH-1:0]  quot,
    output bad_pkg::div_stat_t                    stat
);
    import bad_pkg::*;

    localparam int DW = (AREA_W + CH_W > SUM_W) ? AREA_W + CH_W : SUM_W + 1;

    logic [DW-1:0]     rem_reg  [NUM_CH];
    logic [DW-1:0]     rem_next [NUM_CH];
    chan_t             q_reg    [NUM_CH];
    chan_t             q_next   [NUM_CH];
    logic [DW-1:0]     dvs_reg;
    logic [2:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    // One quotient bit per channel and cycle while busy, most significant bit first.
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (rem_reg[c] >= dvs_reg)
            begin
                rem_next[c] = rem_reg[c] - dvs_reg;
                q_next[c]   = {q_reg[c][CH_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[c] = rem_reg[c];
                q_next[c]   = {q_reg[c][CH_W-2:0], 1'b0};
            end
        end
    end

    // Control of the iteration count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'(CH_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 3'd1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the divisor starts at area times 128 and halves each step.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg <= DW'(area) << (CH_W - 1);
            for (int c = 0; c < NUM_CH; c++)
            begin
                rem_reg[c] <= DW'(sums[c]);
                q_reg[c]   <= '0;
            end
        end
        else if (busy_reg)
        begin
            dvs_reg <= dvs_reg >> 1;
            for (int c = 0; c < NUM_CH; c++)
            begin
                rem_reg[c] <= rem_next[c];
                q_reg[c]   <= q_next[c];
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            quot[c] = q_reg[c];
        end
        stat.busy = busy_reg;
        stat.done = done_reg;
    end

endmodule
